FILE: hdl/lohl_pkg.sv
// Shared types, constants and codes for the open handle limiter.
`timescale 1ns / 1ps
package lohl_pkg;

  localparam int NUM_SLOTS = 32;
  localparam int IDX_W     = $clog2(NUM_SLOTS);
  localparam int SLOT_W    = 5;
  localparam int STAMP_W   = 32;
  localparam int CNT_W     = 6;
  localparam int SCAN_W    = $clog2(NUM_SLOTS + 1);

  localparam logic [CNT_W-1:0] OPEN_LIMIT_RST = CNT_W'(8);

  typedef enum logic [0:0] {
    OP_ACCESS = 1'b0,
    OP_CLOSE  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_OPENED  = 3'd1,
    ST_EVICTED = 3'd2,
    ST_FATAL   = 3'd3,
    ST_CLOSED  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic              operation;
    logic [SLOT_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] victim_index;
    logic [CNT_W-1:0]  open_total;
  } rsp_t;

  // broadcast update to the cell row
  typedef struct packed {
    logic               set_en;
    logic [IDX_W-1:0]   set_idx;
    logic [STAMP_W-1:0] set_stamp;
    logic               clr_en;
    logic [IDX_W-1:0]   clr_idx;
  } cell_cmd_t;

  // running oldest-open candidate passed down the row
  typedef struct packed {
    logic               found;
    logic [STAMP_W-1:0] stamp;
    logic [IDX_W-1:0]   idx;
  } best_t;

endpackage

FILE: hdl/lru_open_handle_limiter_unit.sv
// Top level: control, counters and the row of slot cells.
// An accepted word is evaluated in S_EVAL; a miss at the limit then waits in S_SCAN
// while the oldest-slot search ripples down the cell row (one cell per cycle), and
// the result is registered from S_FINISH once the output is free. One word in flight:
// a new word is taken only in S_IDLE. Reset (synchronous) closes all slots, clears
// the open count, sets the stamp counter to 1 and the limit to 8.
`timescale 1ns / 1ps
module lru_open_handle_limiter_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  lohl_pkg::req_t                 req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output lohl_pkg::rsp_t                 rsp,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lohl_pkg::CNT_W-1:0]     cfg_data
);
  import lohl_pkg::*;

  state_e             state, state_next;
  req_t               cur;
  logic [CNT_W-1:0]   open_limit;
  logic [CNT_W-1:0]   open_count;
  logic [STAMP_W-1:0] next_stamp;
  logic [SCAN_W-1:0]  scan_cnt;

  cell_cmd_t          cmd;
  best_t              chain [NUM_SLOTS+1];
  logic [NUM_SLOTS-1:0] marks;

  logic               req_take, load, out_free;
  logic               in_range, slot_open, need_scan;
  logic [IDX_W-1:0]   cur_idx;
  rsp_t               rsp_next;
  logic [CNT_W-1:0]   count_next;
  logic               stamp_use;

  assign chain[0] = '0;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    lohl_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (IDX_W'(i)),
      .cmd      (cmd),
      .best_in  (chain[i]),
      .best_out (chain[i+1]),
      .mark     (marks[i])
    );
  end

  assign cfg_ready = 1'b1;
  assign req_take  = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  assign in_range  = 32'(cur.slot_index) < NUM_SLOTS;
  assign cur_idx   = IDX_W'(cur.slot_index);
  assign slot_open = in_range && marks[cur_idx];
  assign need_scan = (cur.operation == OP_ACCESS) && in_range && !slot_open
                     && (open_count >= open_limit);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (req_valid) state_next = S_EVAL;
      S_EVAL:   state_next = need_scan ? S_SCAN : S_FINISH;
      S_SCAN:   if (scan_cnt == SCAN_W'(NUM_SLOTS)) state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_stall = (state != S_IDLE);
    load      = (state == S_FINISH) && out_free;
  end

  // outcome of the current word
  always_comb begin
    cmd        = '0;
    rsp_next   = '0;
    count_next = open_count;
    stamp_use  = 1'b0;
    cmd.set_idx   = cur_idx;
    cmd.set_stamp = next_stamp;
    priority if (cur.operation == OP_CLOSE) begin
      rsp_next.status = ST_CLOSED;
      if (slot_open) begin
        cmd.clr_en  = 1'b1;
        cmd.clr_idx = cur_idx;
        if (open_count != '0) count_next = open_count - CNT_W'(1);
      end
    end else if (!in_range) begin
      rsp_next.status = ST_FATAL;
    end else if (slot_open) begin
      rsp_next.status = ST_HIT;
      cmd.set_en      = 1'b1;
      stamp_use       = 1'b1;
    end else if (open_count >= open_limit) begin
      if (!chain[NUM_SLOTS].found) begin
        rsp_next.status = ST_FATAL;
      end else begin
        // victim out, new slot in: count unchanged
        rsp_next.status       = ST_EVICTED;
        rsp_next.victim_index = SLOT_W'(chain[NUM_SLOTS].idx);
        cmd.clr_en            = 1'b1;
        cmd.clr_idx           = chain[NUM_SLOTS].idx;
        cmd.set_en            = 1'b1;
        stamp_use             = 1'b1;
      end
    end else begin
      rsp_next.status = ST_OPENED;
      cmd.set_en      = 1'b1;
      stamp_use       = 1'b1;
      count_next      = open_count + CNT_W'(1);
    end
    rsp_next.open_total = count_next;
    if (!load) begin
      cmd.set_en = 1'b0;
      cmd.clr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      open_limit <= OPEN_LIMIT_RST;
      open_count <= '0;
      next_stamp <= STAMP_W'(1);
      scan_cnt   <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) open_limit <= cfg_data;
      if (state == S_SCAN) scan_cnt <= scan_cnt + SCAN_W'(1);
      else scan_cnt <= '0;
      if (load) begin
        open_count <= count_next;
        if (stamp_use && next_stamp != '1) next_stamp <= next_stamp + STAMP_W'(1);
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) cur <= req;
    if (load) rsp <= rsp_next;
  end

  a_take_eval: assert property (@(posedge clk) disable iff (rst)
    req_take |=> state == S_EVAL)
    else $error("accepted word did not move to evaluation");

  a_count_marks: assert property (@(posedge clk) disable iff (rst)
    $countones(marks) == 32'(open_count))
    else $error("open count disagrees with open marks");

  a_victim_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_EVICTED) |-> rsp.victim_index == '0)
    else $error("victim index set without eviction");

  a_scan_found: assert property (@(posedge clk) disable iff (rst)
    (load && rsp_next.status == ST_EVICTED) |-> marks[chain[NUM_SLOTS].idx])
    else $error("evicted slot is not open");

endmodule

FILE: hdl/lohl_cell.sv
// One slot cell: open mark, use stamp and one stage of the oldest-slot search.
`timescale 1ns / 1ps
module lohl_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [lohl_pkg::IDX_W-1:0] cell_idx,
  input  lohl_pkg::cell_cmd_t      cmd,
  input  lohl_pkg::best_t          best_in,
  output lohl_pkg::best_t          best_out,
  output logic                     mark
);
  import lohl_pkg::*;

  logic [STAMP_W-1:0] stamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      mark  <= 1'b0;
      stamp <= '0;
    end else begin
      if (cmd.set_en && cmd.set_idx == cell_idx) begin
        mark  <= 1'b1;
        stamp <= cmd.set_stamp;
      end else if (cmd.clr_en && cmd.clr_idx == cell_idx) begin
        mark <= 1'b0;
      end
    end
  end

  // strict less-than keeps the lower index on a tie
  always_ff @(posedge clk) begin
    if (rst) begin
      best_out.found <= 1'b0;
    end else if (mark && (!best_in.found || stamp < best_in.stamp)) begin
      best_out.found <= 1'b1;
      best_out.stamp <= stamp;
      best_out.idx   <= cell_idx;
    end else begin
      best_out <= best_in;
    end
  end

endmodule
